// ===== rtl/mfst_pkg.sv =====
// ----------------------------------------------------------------------------
// mfst_pkg
// Shared types and codes of the minimal filter set table: beat payloads,
// mode and status codes, and the control passed from the sets to their cells.
// ----------------------------------------------------------------------------
package mfst_pkg;

    localparam int DEF_SET_DEPTH   = 32;
    localparam int DEF_FILTER_BITS = 64;
    localparam int DATA_W          = 64;
    localparam int CNT_W           = 6;

    localparam logic [2:0] MODE_INS_REM  = 3'd0;
    localparam logic [2:0] MODE_INS_ADD  = 3'd1;
    localparam logic [2:0] MODE_DUMP_REM = 3'd2;
    localparam logic [2:0] MODE_DUMP_ADD = 3'd3;
    localparam logic [2:0] MODE_CLEAR    = 3'd4;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_COVERED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_DUMP    = 2'd3;

    typedef struct packed {
        logic [2:0]        mode;
        logic [DATA_W-1:0] filter;
    } t_in_beat;

    typedef struct packed {
        logic [DATA_W-1:0] entry_value;
        logic              entry_valid;
        logic              is_last;
        logic [1:0]        status;
        logic [CNT_W-1:0]  evicted_count;
        logic [CNT_W-1:0]  occupancy;
    } t_out_beat;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_MATCH,
        OP_COMPACT,
        OP_ROTATE,
        OP_APPEND,
        OP_CLEAR
    } t_cell_op;

    typedef struct packed {
        logic in_use;
        logic is_tail;
        logic is_free;
    } t_cell_pos;

    typedef struct packed {
        logic covered;
        logic any_dead;
    } t_chain_stat;

endpackage

// ===== rtl/mfst_cell.sv =====
// ----------------------------------------------------------------------------
// mfst_cell
// One slot of a filter set: holds an entry and its evict flag, compares the
// entry against the incoming filter, and takes its right neighbor on a shift.
// ----------------------------------------------------------------------------
module mfst_cell #(
    parameter int FILTER_BITS = mfst_pkg::DEF_FILTER_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mfst_pkg::t_cell_op     i_op,
    input  mfst_pkg::t_cell_pos    i_pos,
    input  logic [FILTER_BITS-1:0] i_filter,
    input  logic [FILTER_BITS-1:0] i_right,
    input  logic                   i_right_dead,
    input  logic [FILTER_BITS-1:0] i_head,
    input  logic                   i_dead_pfx,
    output logic [FILTER_BITS-1:0] o_entry,
    output logic                   o_dead,
    output logic                   o_dead_pfx,
    output logic                   o_covers
);

    logic [FILTER_BITS-1:0] r_entry;
    logic                   r_dead;

    assign o_entry    = r_entry;
    assign o_dead     = r_dead;
    assign o_dead_pfx = i_dead_pfx | r_dead;
    assign o_covers   = i_pos.in_use && ((r_entry & ~i_filter) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead <= 1'b0;
        end else begin
            case (i_op)
                mfst_pkg::OP_MATCH: begin
                    r_dead <= i_pos.in_use && ((i_filter & ~r_entry) == '0);
                end
                mfst_pkg::OP_COMPACT: begin
                    if (o_dead_pfx) begin
                        r_dead <= i_right_dead;
                    end
                end
                default: begin
                    r_dead <= r_dead;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            mfst_pkg::OP_COMPACT: begin
                if (o_dead_pfx) begin
                    r_entry <= i_right;
                end
            end
            mfst_pkg::OP_ROTATE: begin
                if (i_pos.is_tail) begin
                    r_entry <= i_head;
                end else if (i_pos.in_use) begin
                    r_entry <= i_right;
                end
            end
            mfst_pkg::OP_APPEND: begin
                if (i_pos.is_free) begin
                    r_entry <= i_filter;
                end
            end
            default: begin
                r_entry <= r_entry;
            end
        endcase
    end

endmodule

// ===== rtl/mfst_chain.sv =====
// ----------------------------------------------------------------------------
// mfst_chain
// One ordered filter set: a row of cells plus the fill count. Evicted cells
// are squeezed out one per cycle, a dump rotates the used cells past the head.
// ----------------------------------------------------------------------------
module mfst_chain #(
    parameter int SET_DEPTH   = mfst_pkg::DEF_SET_DEPTH,
    parameter int FILTER_BITS = mfst_pkg::DEF_FILTER_BITS,
    parameter int CW          = $clog2(SET_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mfst_pkg::t_cell_op     i_op,
    input  logic [FILTER_BITS-1:0] i_filter,
    output mfst_pkg::t_chain_stat  o_stat,
    output logic [CW-1:0]          o_count,
    output logic [FILTER_BITS-1:0] o_head
);

    logic [CW-1:0]          r_count;
    logic [FILTER_BITS-1:0] w_entry [SET_DEPTH];
    logic [SET_DEPTH-1:0]   w_dead;
    logic [SET_DEPTH-1:0]   w_pfx;
    logic [SET_DEPTH-1:0]   w_cov;

    assign o_count         = r_count;
    assign o_head          = w_entry[0];
    assign o_stat.covered  = |w_cov;
    assign o_stat.any_dead = w_pfx[SET_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_op)
                mfst_pkg::OP_COMPACT: r_count <= r_count - CW'(1);
                mfst_pkg::OP_APPEND:  r_count <= r_count + CW'(1);
                mfst_pkg::OP_CLEAR:   r_count <= '0;
                default:              r_count <= r_count;
            endcase
        end
    end

    for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
        mfst_pkg::t_cell_pos    w_pos;
        logic [FILTER_BITS-1:0] w_right;
        logic                   w_right_dead;
        logic                   w_pfx_in;

        assign w_pos.in_use  = CW'(i) < r_count;
        assign w_pos.is_tail = CW'(i + 1) == r_count;
        assign w_pos.is_free = CW'(i) == r_count;

        if (i == SET_DEPTH - 1) begin : g_last
            assign w_right      = '0;
            assign w_right_dead = 1'b0;
        end else begin : g_mid
            assign w_right      = w_entry[i+1];
            assign w_right_dead = w_dead[i+1];
        end

        if (i == 0) begin : g_first
            assign w_pfx_in = 1'b0;
        end else begin : g_rest
            assign w_pfx_in = w_pfx[i-1];
        end

        mfst_cell #(
            .FILTER_BITS (FILTER_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (i_op),
            .i_pos        (w_pos),
            .i_filter     (i_filter),
            .i_right      (w_right),
            .i_right_dead (w_right_dead),
            .i_head       (w_entry[0]),
            .i_dead_pfx   (w_pfx_in),
            .o_entry      (w_entry[i]),
            .o_dead       (w_dead[i]),
            .o_dead_pfx   (w_pfx[i]),
            .o_covers     (w_cov[i])
        );
    end

endmodule

// ===== rtl/minimal_filter_set_table_core.sv =====
// ----------------------------------------------------------------------------
// minimal_filter_set_table_core
// Two minimal filter sets (removal, addition) under bitwise containment.
//
// Input channel i_in_valid / o_in_stall carries one operation per beat:
// insert into a set, dump a set, or clear both. Output channel
// o_out_valid / i_out_stall carries the result beats; every operation ends
// with a beat that has is_last set, unused mode codes give no beat.
// An insert compares in S_MATCH over all cells; a covered filter goes straight
// to S_EMIT, else S_COMPACT squeezes out one evicted entry per step and then
// appends unless the set is full; S_EMIT registers the result in the output.
// A dump posts one beat per cycle while the output register is free, one per
// stored entry or one empty beat if none, as the row rotates past its head.
// A clear empties both sets at acceptance and posts its beat through S_EMIT.
// o_in_stall is high while an operation is in flight; the block takes the
// next beat while the last result still sits in the output register.
// When the receiver stalls, the output register holds its beat and a dump or
// a result in S_EMIT waits. Reset empties both sets and the output.
// ----------------------------------------------------------------------------
module minimal_filter_set_table_core #(
    parameter int SET_DEPTH   = mfst_pkg::DEF_SET_DEPTH,
    parameter int FILTER_BITS = mfst_pkg::DEF_FILTER_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  mfst_pkg::t_in_beat  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output mfst_pkg::t_out_beat o_out_data,
    input  logic                i_out_stall
);

    localparam int CW = $clog2(SET_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_COMPACT,
        S_DUMP,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic                    r_sel;
    logic [FILTER_BITS-1:0]  r_filter;
    logic [CW-1:0]           r_ev;
    logic [CW-1:0]           r_idx;
    mfst_pkg::t_out_beat     r_res;
    mfst_pkg::t_out_beat     r_out;
    logic                    r_out_valid;

    mfst_pkg::t_cell_op      w_op_rem;
    mfst_pkg::t_cell_op      w_op_add;
    mfst_pkg::t_cell_op      w_op;
    mfst_pkg::t_chain_stat   w_stat_rem;
    mfst_pkg::t_chain_stat   w_stat_add;
    mfst_pkg::t_chain_stat   w_stat;
    logic [CW-1:0]           w_cnt_rem;
    logic [CW-1:0]           w_cnt_add;
    logic [CW-1:0]           w_count;
    logic [FILTER_BITS-1:0]  w_head_rem;
    logic [FILTER_BITS-1:0]  w_head_add;
    logic [FILTER_BITS-1:0]  w_head;
    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_out_load;
    logic                    w_full;
    logic                    w_dump_last;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_out_load  = w_out_free && (r_state == S_DUMP || r_state == S_EMIT);

    assign w_stat      = r_sel ? w_stat_add : w_stat_rem;
    assign w_count     = r_sel ? w_cnt_add : w_cnt_rem;
    assign w_head      = r_sel ? w_head_add : w_head_rem;
    assign w_full      = (w_count == CW'(SET_DEPTH));
    assign w_dump_last = ((r_idx + CW'(1)) == w_count);

    always_comb begin
        w_op = mfst_pkg::OP_HOLD;
        case (r_state)
            S_MATCH: w_op = mfst_pkg::OP_MATCH;
            S_COMPACT: begin
                if (w_stat.any_dead) begin
                    w_op = mfst_pkg::OP_COMPACT;
                end else if (!w_full) begin
                    w_op = mfst_pkg::OP_APPEND;
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    w_op = mfst_pkg::OP_ROTATE;
                end
            end
            default: w_op = mfst_pkg::OP_HOLD;
        endcase
    end

    always_comb begin
        w_op_rem = r_sel ? mfst_pkg::OP_HOLD : w_op;
        w_op_add = r_sel ? w_op : mfst_pkg::OP_HOLD;
        if (r_state == S_IDLE && w_in_acc && i_in_data.mode == mfst_pkg::MODE_CLEAR) begin
            w_op_rem = mfst_pkg::OP_CLEAR;
            w_op_add = mfst_pkg::OP_CLEAR;
        end
    end

    mfst_chain #(
        .SET_DEPTH   (SET_DEPTH),
        .FILTER_BITS (FILTER_BITS),
        .CW          (CW)
    ) u_rem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op_rem),
        .i_filter (r_filter),
        .o_stat   (w_stat_rem),
        .o_count  (w_cnt_rem),
        .o_head   (w_head_rem)
    );

    mfst_chain #(
        .SET_DEPTH   (SET_DEPTH),
        .FILTER_BITS (FILTER_BITS),
        .CW          (CW)
    ) u_add (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op_add),
        .i_filter (r_filter),
        .o_stat   (w_stat_add),
        .o_count  (w_cnt_add),
        .o_head   (w_head_add)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sel       <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_filter <= i_in_data.filter[FILTER_BITS-1:0];
                        r_sel    <= i_in_data.mode[0];
                        r_ev     <= '0;
                        r_idx    <= '0;
                        case (i_in_data.mode)
                            mfst_pkg::MODE_INS_REM,
                            mfst_pkg::MODE_INS_ADD: begin
                                r_state <= S_MATCH;
                            end
                            mfst_pkg::MODE_DUMP_REM,
                            mfst_pkg::MODE_DUMP_ADD: begin
                                r_state <= S_DUMP;
                            end
                            mfst_pkg::MODE_CLEAR: begin
                                r_res.entry_value   <= '0;
                                r_res.entry_valid   <= 1'b0;
                                r_res.is_last       <= 1'b1;
                                r_res.status        <= mfst_pkg::ST_DUMP;
                                r_res.evicted_count <= '0;
                                r_res.occupancy     <= '0;
                                r_state             <= S_EMIT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MATCH: begin
                    if (w_stat.covered) begin
                        r_res.entry_value   <= '0;
                        r_res.entry_valid   <= 1'b0;
                        r_res.is_last       <= 1'b1;
                        r_res.status        <= mfst_pkg::ST_COVERED;
                        r_res.evicted_count <= '0;
                        r_res.occupancy     <= mfst_pkg::CNT_W'(w_count);
                        r_state             <= S_EMIT;
                    end else begin
                        r_state <= S_COMPACT;
                    end
                end
                S_COMPACT: begin
                    if (w_stat.any_dead) begin
                        r_ev <= r_ev + CW'(1);
                    end else begin
                        r_res.entry_value   <= '0;
                        r_res.entry_valid   <= 1'b0;
                        r_res.is_last       <= 1'b1;
                        r_res.evicted_count <= mfst_pkg::CNT_W'(r_ev);
                        if (w_full) begin
                            r_res.status    <= mfst_pkg::ST_FULL;
                            r_res.occupancy <= mfst_pkg::CNT_W'(w_count);
                        end else begin
                            r_res.status    <= mfst_pkg::ST_STORED;
                            r_res.occupancy <= mfst_pkg::CNT_W'(w_count + CW'(1));
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_DUMP: begin
                    if (w_out_free) begin
                        r_out_valid           <= 1'b1;
                        r_out.status          <= mfst_pkg::ST_DUMP;
                        r_out.evicted_count   <= '0;
                        r_out.occupancy       <= mfst_pkg::CNT_W'(w_count);
                        r_idx                 <= r_idx + CW'(1);
                        if (w_count == '0) begin
                            r_out.entry_value <= '0;
                            r_out.entry_valid <= 1'b0;
                            r_out.is_last     <= 1'b1;
                            r_state           <= S_IDLE;
                        end else begin
                            r_out.entry_value <= mfst_pkg::DATA_W'(w_head);
                            r_out.entry_valid <= 1'b1;
                            r_out.is_last     <= w_dump_last;
                            if (w_dump_last) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/mfst_checker.sv =====
// ----------------------------------------------------------------------------
// mfst_checker
// Port-level checks of the minimal filter set table, bound to the top level.
// ----------------------------------------------------------------------------
module mfst_checker #(
    parameter int SET_DEPTH = mfst_pkg::DEF_SET_DEPTH
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input mfst_pkg::t_in_beat  i_in_data,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input mfst_pkg::t_out_beat o_out_data,
    input logic                i_out_stall
);

    // an accepted insert keeps the input stalled for its compare state
    a_insert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall
        && (i_in_data.mode == mfst_pkg::MODE_INS_REM
            || i_in_data.mode == mfst_pkg::MODE_INS_ADD)
        |=> o_in_stall)
        else $error("insert did not hold off the input");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    // insert results are single beats without an entry
    a_insert_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != mfst_pkg::ST_DUMP
        |-> !o_out_data.entry_valid && o_out_data.is_last)
        else $error("insert result beat malformed");

    a_entry_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.entry_valid
        |-> o_out_data.status == mfst_pkg::ST_DUMP && o_out_data.evicted_count == '0)
        else $error("entry beat outside a dump");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && SET_DEPTH < 64
        |-> o_out_data.occupancy <= mfst_pkg::CNT_W'(SET_DEPTH)
            && o_out_data.evicted_count <= mfst_pkg::CNT_W'(SET_DEPTH))
        else $error("occupancy beyond set depth");

endmodule

bind minimal_filter_set_table_core mfst_checker #(
    .SET_DEPTH (SET_DEPTH)
) u_mfst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
